/* design/nil_pkg.sv */
package nil_pkg;

    localparam int POS_W = 16;
    localparam int LEN_W = 8;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);

    localparam logic [1:0] K_ID      = 2'd0;
    localparam logic [1:0] K_INT     = 2'd1;
    localparam logic [1:0] K_FLOAT   = 2'd2;
    localparam logic [1:0] K_ILLEGAL = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic             malformed;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] column;
        logic [LEN_W-1:0] length;
        logic             last;
    } token_t;

    // up to two tokens per source byte: a closed one, then an illegal byte
    typedef struct packed {
        logic   v0;
        logic   v1;
        token_t r0;
        token_t r1;
    } scan_out_t;

endpackage

/* design/number_and_identifier_lexer.sv */
// Streaming scanner for identifiers and numeric literals. One source byte is
// taken per request, one per clock when the output side keeps up; in_ready
// depends only on the fill of a four-entry token queue, never on out_ready in
// the same cycle. Each byte updates the scan state and its tokens are written
// into the queue at the same edge; a token reaches the output once the tokens
// ahead of it in the queue have been taken. A byte that ends an open token
// and is itself an illegal byte yields two tokens; the queue drains one token
// per cycle while out_ready is high, and in_ready drops whenever fewer than
// two entries are free. end_of_text flushes an open token without moving the
// line/column position. last_of_run marks the final token caused by a byte.
module number_and_identifier_lexer (
    input  logic                       clk,
    input  logic                       rst_n,
    // source byte requests
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 text_byte,
    input  logic                       end_of_text,
    // token requests
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 token_kind,
    output logic                       malformed,
    output logic [nil_pkg::POS_W-1:0]  start_line,
    output logic [nil_pkg::POS_W-1:0]  start_column,
    output logic [nil_pkg::LEN_W-1:0]  token_length,
    output logic                       last_of_run
);

    nil_pkg::scan_out_t scan_res;
    nil_pkg::token_t    head;
    logic               room;
    logic               accept;

    assign in_ready = room;
    assign accept   = in_valid && room;

    // scan state machine: closes, extends or opens a token per byte
    nil_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .res         (scan_res)
    );

    // token queue decouples the two sides
    nil_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (scan_res),
        .room    (room),
        .q_valid (out_valid),
        .q_ready (out_ready),
        .q_data  (head)
    );

    assign token_kind   = head.kind;
    assign malformed    = head.malformed;
    assign start_line   = head.line;
    assign start_column = head.column;
    assign token_length = head.length;
    assign last_of_run  = head.last;

endmodule

/* design/nil_scan.sv */
module nil_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         text_byte,
    input  logic               end_of_text,
    output nil_pkg::scan_out_t res
);

    typedef enum logic [10:0] {
        M_IDLE       = 11'b000_0000_0001,
        M_IDENT      = 11'b000_0000_0010,
        M_ZERO       = 11'b000_0000_0100,
        M_INT        = 11'b000_0000_1000,
        M_PREFIX     = 11'b000_0001_0000,
        M_PREFIX_DIG = 11'b000_0010_0000,
        M_FRAC_START = 11'b000_0100_0000,
        M_FRAC_DIG   = 11'b000_1000_0000,
        M_EXP_START  = 11'b001_0000_0000,
        M_EXP_SIGN   = 11'b010_0000_0000,
        M_EXP_DIG    = 11'b100_0000_0000
    } mode_t;

    localparam logic [4:0] BASE_2  = 5'd2;
    localparam logic [4:0] BASE_8  = 5'd8;
    localparam logic [4:0] BASE_10 = 5'd10;
    localparam logic [4:0] BASE_16 = 5'd16;

    function automatic logic is_dec(input logic [7:0] c);
        is_dec = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
                   || (c == 8'h5F);
    endfunction

    // space, LF, CR, TAB, VT
    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'h20) || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09)
                   || (c == 8'h0B);
    endfunction

    // digit value, 16 for anything that is no hex digit
    function automatic logic [4:0] value_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (is_dec(c))
            d = c - 8'h30;
        else if ((c >= 8'h61) && (c <= 8'h66))
            d = c - 8'h57;
        else if ((c >= 8'h41) && (c <= 8'h46))
            d = c - 8'h37;
        else
            d = 8'd16;
        value_of = d[4:0];
    endfunction

    mode_t                       mode_reg, mode_next;
    logic [4:0]                  base_reg, base_next;
    logic [1:0]                  kind_reg, kind_next;
    logic                        err_reg, err_next;
    logic [nil_pkg::POS_W-1:0]   tok_line_reg, tok_line_next;
    logic [nil_pkg::POS_W-1:0]   tok_col_reg, tok_col_next;
    logic [nil_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [nil_pkg::POS_W-1:0]   cur_line_reg, cur_line_next;
    logic [nil_pkg::POS_W-1:0]   cur_col_reg, cur_col_next;

    logic                        ext;
    logic                        is_e;
    logic                        needs_digits;
    nil_pkg::token_t             close_tok;
    nil_pkg::token_t             ill_tok;

    always_comb
    begin
        needs_digits = (mode_reg == M_PREFIX) || (mode_reg == M_FRAC_START)
                       || (mode_reg == M_EXP_START) || (mode_reg == M_EXP_SIGN);
        close_tok.kind      = kind_reg;
        close_tok.malformed = (kind_reg != nil_pkg::K_ID) && (err_reg || needs_digits);
        close_tok.line      = tok_line_reg;
        close_tok.column    = tok_col_reg;
        close_tok.length    = len_reg;
        close_tok.last      = 1'b1;

        ill_tok.kind      = nil_pkg::K_ILLEGAL;
        ill_tok.malformed = 1'b0;
        ill_tok.line      = cur_line_reg;
        ill_tok.column    = cur_col_reg;
        ill_tok.length    = nil_pkg::LEN_W'(1);
        ill_tok.last      = 1'b1;
    end

    always_comb
    begin
        mode_next     = mode_reg;
        base_next     = base_reg;
        kind_next     = kind_reg;
        err_next      = err_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        len_next      = len_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        res           = '0;
        ext           = 1'b0;
        is_e          = (text_byte == 8'h65) || (text_byte == 8'h45);

        if (accept)
        begin
            if (end_of_text)
            begin
                if (mode_reg != M_IDLE)
                begin
                    res.v0 = 1'b1;
                    res.r0 = close_tok;
                    mode_next = M_IDLE;
                    base_next = BASE_10;
                    kind_next = nil_pkg::K_ID;
                    err_next  = 1'b0;
                    len_next  = '0;
                end
            end
            else
            begin
                // try to extend the open token
                unique case (mode_reg) inside
                    M_IDLE:
                        ext = 1'b0;
                    M_IDENT:
                        ext = is_alpha(text_byte) || is_dec(text_byte);
                    M_ZERO, M_INT:
                    begin
                        if ((mode_reg == M_ZERO) &&
                            ((text_byte == 8'h62) || (text_byte == 8'h42)))
                        begin
                            ext = 1'b1; base_next = BASE_2; mode_next = M_PREFIX;
                        end
                        else if ((mode_reg == M_ZERO) &&
                            ((text_byte == 8'h6F) || (text_byte == 8'h4F)))
                        begin
                            ext = 1'b1; base_next = BASE_8; mode_next = M_PREFIX;
                        end
                        else if ((mode_reg == M_ZERO) &&
                            ((text_byte == 8'h64) || (text_byte == 8'h44)))
                        begin
                            ext = 1'b1; base_next = BASE_10; mode_next = M_PREFIX;
                        end
                        else if ((mode_reg == M_ZERO) &&
                            ((text_byte == 8'h78) || (text_byte == 8'h58)))
                        begin
                            ext = 1'b1; base_next = BASE_16; mode_next = M_PREFIX;
                        end
                        else if (is_dec(text_byte))
                        begin
                            ext = 1'b1; mode_next = M_INT;
                        end
                        else if (text_byte == 8'h2E)
                        begin
                            ext = 1'b1; kind_next = nil_pkg::K_FLOAT;
                            mode_next = M_FRAC_START;
                        end
                        else if (is_e)
                        begin
                            ext = 1'b1; kind_next = nil_pkg::K_FLOAT;
                            mode_next = M_EXP_START;
                        end
                    end
                    M_PREFIX, M_PREFIX_DIG:
                    begin
                        if (value_of(text_byte) < base_reg)
                        begin
                            ext = 1'b1; mode_next = M_PREFIX_DIG;
                        end
                    end
                    M_FRAC_START, M_FRAC_DIG:
                    begin
                        if (is_dec(text_byte))
                        begin
                            ext = 1'b1; mode_next = M_FRAC_DIG;
                        end
                        else if (is_e)
                        begin
                            ext = 1'b1; mode_next = M_EXP_START;
                            // fraction point with no digit behind it
                            if (mode_reg == M_FRAC_START)
                                err_next = 1'b1;
                        end
                    end
                    M_EXP_START, M_EXP_SIGN, M_EXP_DIG:
                    begin
                        if ((mode_reg == M_EXP_START) &&
                            ((text_byte == 8'h2B) || (text_byte == 8'h2D)))
                        begin
                            ext = 1'b1; mode_next = M_EXP_SIGN;
                        end
                        else if (is_dec(text_byte))
                        begin
                            ext = 1'b1; mode_next = M_EXP_DIG;
                        end
                    end
                    default:
                        ext = 1'b0;
                endcase

                if (mode_reg != M_IDLE && ext)
                begin
                    if (len_reg != '1)
                        len_next = len_reg + nil_pkg::LEN_W'(1);
                end
                else
                begin
                    if (mode_reg != M_IDLE)
                    begin
                        res.v0 = 1'b1;
                        res.r0 = close_tok;
                    end
                    mode_next = M_IDLE;
                    base_next = BASE_10;
                    kind_next = nil_pkg::K_ID;
                    err_next  = 1'b0;
                    len_next  = '0;
                    // the same byte may open the next token
                    if (!is_space(text_byte))
                    begin
                        if (is_alpha(text_byte) || is_dec(text_byte))
                        begin
                            tok_line_next = cur_line_reg;
                            tok_col_next  = cur_col_reg;
                            len_next      = nil_pkg::LEN_W'(1);
                            if (is_alpha(text_byte))
                            begin
                                mode_next = M_IDENT;
                            end
                            else
                            begin
                                kind_next = nil_pkg::K_INT;
                                mode_next = (text_byte == 8'h30) ? M_ZERO : M_INT;
                            end
                        end
                        else if (res.v0)
                        begin
                            res.v1      = 1'b1;
                            res.r1      = ill_tok;
                            res.r0.last = 1'b0;
                        end
                        else
                        begin
                            res.v0 = 1'b1;
                            res.r0 = ill_tok;
                        end
                    end
                end

                if (text_byte == 8'h0A)
                begin
                    if (cur_line_reg != '1)
                        cur_line_next = cur_line_reg + nil_pkg::POS_W'(1);
                    cur_col_next = nil_pkg::POS_W'(1);
                end
                else if (cur_col_reg != '1)
                begin
                    cur_col_next = cur_col_reg + nil_pkg::POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            base_reg     <= BASE_10;
            kind_reg     <= nil_pkg::K_ID;
            err_reg      <= 1'b0;
            tok_line_reg <= nil_pkg::POS_W'(1);
            tok_col_reg  <= nil_pkg::POS_W'(1);
            len_reg      <= '0;
            cur_line_reg <= nil_pkg::POS_W'(1);
            cur_col_reg  <= nil_pkg::POS_W'(1);
        end
        else
        begin
            mode_reg     <= mode_next;
            base_reg     <= base_next;
            kind_reg     <= kind_next;
            err_reg      <= err_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            len_reg      <= len_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
        end
    end

endmodule

/* design/nil_outq.sv */
module nil_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  nil_pkg::scan_out_t push,
    output logic               room,
    output logic               q_valid,
    input  logic               q_ready,
    output nil_pkg::token_t    q_data
);

    nil_pkg::token_t           mem [nil_pkg::Q_DEPTH];
    logic [nil_pkg::Q_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [nil_pkg::Q_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [nil_pkg::Q_AW:0]    count_reg, count_next;
    logic                      pop;

    // room for the worst case of two tokens from one byte
    assign room    = count_reg <= (nil_pkg::Q_AW + 1)'(nil_pkg::Q_DEPTH - 2);
    assign q_valid = count_reg != '0;
    assign q_data  = mem[rd_ptr_reg];
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + nil_pkg::Q_AW'(push.v0) + nil_pkg::Q_AW'(push.v1);
        rd_ptr_next = rd_ptr_reg + nil_pkg::Q_AW'(pop);
        count_next  = count_reg + (nil_pkg::Q_AW + 1)'(push.v0)
                      + (nil_pkg::Q_AW + 1)'(push.v1) - (nil_pkg::Q_AW + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
            mem[wr_ptr_reg] <= push.r0;
        if (push.v1)
            mem[wr_ptr_reg + nil_pkg::Q_AW'(1)] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/nil_checker.sv */
module nil_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [1:0]                 token_kind,
    input logic                       malformed,
    input logic [nil_pkg::POS_W-1:0]  start_line,
    input logic [nil_pkg::POS_W-1:0]  start_column,
    input logic [nil_pkg::LEN_W-1:0]  token_length,
    input logic                       last_of_run
);

    // stalled token holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind)
        && $stable(start_line) && $stable(start_column) && $stable(token_length)
        && $stable(last_of_run))
        else $error("token changed while stalled");

    a_illegal_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == nil_pkg::K_ILLEGAL |->
        token_length == nil_pkg::LEN_W'(1) && !malformed)
        else $error("illegal token must be one clean byte");

    a_ident_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == nil_pkg::K_ID |-> !malformed)
        else $error("identifier flagged malformed");

    a_sane_token: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_length != '0 && start_line != '0 && start_column != '0)
        else $error("token with zero length or position");

endmodule

bind number_and_identifier_lexer nil_checker u_nil_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .malformed    (malformed),
    .start_line   (start_line),
    .start_column (start_column),
    .token_length (token_length),
    .last_of_run  (last_of_run)
);

/* bench/tb_number_and_identifier_lexer.sv */
`timescale 1ns / 1ps

module tb_number_and_identifier_lexer;

    // Random part stops after this many source bytes (end-of-text requests
    // are not counted, most of them are ignored by the scanner).
    localparam int          RANDOM_BYTES = 880;
    // Hang guard, several times a worst-case run with every byte giving two
    // tokens behind the longest output stalls.
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;

    // Character classes used by the stimulus
    localparam string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string WORDCH  = {LETTERS, "0123456789"};
    localparam string DIGITS  = "0123456789";
    localparam string PUNCT   = "!\"#$%&'()*+,-./:;<=>?@[\\]^`{|}~";

    // Scanner position inside the token currently open
    typedef enum logic [10:0] {
        S_IDLE       = 11'b000_0000_0001,
        S_IDENT      = 11'b000_0000_0010,
        S_ZERO       = 11'b000_0000_0100,
        S_INT        = 11'b000_0000_1000,
        S_PREFIX     = 11'b000_0001_0000,
        S_PREFIX_DIG = 11'b000_0010_0000,
        S_FRAC_START = 11'b000_0100_0000,
        S_FRAC_DIG   = 11'b000_1000_0000,
        S_EXP_START  = 11'b001_0000_0000,
        S_EXP_SIGN   = 11'b010_0000_0000,
        S_EXP_DIG    = 11'b100_0000_0000
    } scan_mode_t;

    // Tracks the scan state of the block, turns every accepted source byte
    // into the tokens it must produce and matches them against the output.
    class token_scoreboard;
        scan_mode_t                 mode;
        int unsigned                radix;
        logic [1:0]                 kind_acc;
        bit                         digits_missing;
        logic [nil_pkg::POS_W-1:0]  tok_line;
        logic [nil_pkg::POS_W-1:0]  tok_col;
        logic [nil_pkg::LEN_W-1:0]  tok_len;
        logic [nil_pkg::POS_W-1:0]  cur_line;
        logic [nil_pkg::POS_W-1:0]  cur_col;
        nil_pkg::token_t            due_tokens[$];
        int                         fail_count;

        function new();
            mode           = S_IDLE;
            radix          = 10;
            kind_acc       = nil_pkg::K_ID;
            digits_missing = 1'b0;
            tok_line       = nil_pkg::POS_W'(1);
            tok_col        = nil_pkg::POS_W'(1);
            tok_len        = '0;
            cur_line       = nil_pkg::POS_W'(1);
            cur_col        = nil_pkg::POS_W'(1);
            fail_count     = 0;
        endfunction

        function int pending();
            return due_tokens.size();
        endfunction

        function bit dec_char(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit word_start(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        endfunction

        function nil_pkg::token_t make_token(logic [1:0] kind, logic bad,
                                             logic [nil_pkg::POS_W-1:0] line,
                                             logic [nil_pkg::POS_W-1:0] col,
                                             logic [nil_pkg::LEN_W-1:0] len);
            nil_pkg::token_t t;
            t           = '0;
            t.kind      = kind;
            t.malformed = bad;
            t.line      = line;
            t.column    = col;
            t.length    = len;
            return t;
        endfunction

        // Report the open token and go back to idle
        function nil_pkg::token_t close_open();
            logic            bad;
            nil_pkg::token_t t;
            bad = digits_missing || mode inside {S_PREFIX, S_FRAC_START, S_EXP_START,
                                                 S_EXP_SIGN};
            if (kind_acc == nil_pkg::K_ID)
                bad = 1'b0;
            t              = make_token(kind_acc, bad, tok_line, tok_col, tok_len);
            mode           = S_IDLE;
            radix          = 10;
            kind_acc       = nil_pkg::K_ID;
            digits_missing = 1'b0;
            tok_len        = '0;
            return t;
        endfunction

        function void note_request(logic [7:0] c, logic eot);
            nil_pkg::token_t made[$];
            int unsigned     pfx_radix;
            int unsigned     digit_val;
            bit              grows;
            bit              is_e;
            scan_mode_t      m;

            grows = 1'b0;
            is_e  = (c == "e" || c == "E");
            case (c)
                "b", "B": pfx_radix = 2;
                "o", "O": pfx_radix = 8;
                "d", "D": pfx_radix = 10;
                "x", "X": pfx_radix = 16;
                default:  pfx_radix = 0;
            endcase
            if (dec_char(c))
                digit_val = c - "0";
            else if (c >= "a" && c <= "f")
                digit_val = c - "a" + 10;
            else if (c >= "A" && c <= "F")
                digit_val = c - "A" + 10;
            else
                digit_val = 16;

            if (eot)
            begin
                if (mode != S_IDLE)
                    made.push_back(close_open());
            end
            else
            begin
                if (mode != S_IDLE)
                begin
                    m = mode;
                    case (m)
                        S_IDENT:
                            grows = word_start(c) || dec_char(c);
                        S_ZERO, S_INT:
                        begin
                            grows = 1'b1;
                            if (m == S_ZERO && pfx_radix != 0)
                            begin
                                radix = pfx_radix;
                                mode  = S_PREFIX;
                            end
                            else if (dec_char(c))
                            begin
                                mode = S_INT;
                            end
                            else if (c == ".")
                            begin
                                kind_acc = nil_pkg::K_FLOAT;
                                mode     = S_FRAC_START;
                            end
                            else if (is_e)
                            begin
                                kind_acc = nil_pkg::K_FLOAT;
                                mode     = S_EXP_START;
                            end
                            else
                            begin
                                grows = 1'b0;
                            end
                        end
                        S_PREFIX, S_PREFIX_DIG:
                        begin
                            if (digit_val < radix)
                            begin
                                mode  = S_PREFIX_DIG;
                                grows = 1'b1;
                            end
                        end
                        S_FRAC_START, S_FRAC_DIG:
                        begin
                            if (dec_char(c))
                            begin
                                mode  = S_FRAC_DIG;
                                grows = 1'b1;
                            end
                            else if (is_e)
                            begin
                                // dot with no digits: flag sticks through the exponent
                                if (m == S_FRAC_START)
                                    digits_missing = 1'b1;
                                mode  = S_EXP_START;
                                grows = 1'b1;
                            end
                        end
                        S_EXP_START, S_EXP_SIGN, S_EXP_DIG:
                        begin
                            if (m == S_EXP_START && (c == "+" || c == "-"))
                            begin
                                mode  = S_EXP_SIGN;
                                grows = 1'b1;
                            end
                            else if (dec_char(c))
                            begin
                                mode  = S_EXP_DIG;
                                grows = 1'b1;
                            end
                        end
                        default:
                            grows = 1'b0;
                    endcase
                    if (grows)
                    begin
                        if (tok_len != '1)
                            tok_len++;
                    end
                    else
                    begin
                        made.push_back(close_open());
                    end
                end

                // the byte that closed a token may open the next one
                if (mode == S_IDLE && made.size() <= 1 &&
                    !(made.size() == 0 && tok_len != 0))
                begin
                    if (!(c == " " || c == 8'h0A || c == 8'h0D || c == 8'h09 ||
                          c == 8'h0B))
                    begin
                        tok_line       = cur_line;
                        tok_col        = cur_col;
                        tok_len        = nil_pkg::LEN_W'(1);
                        digits_missing = 1'b0;
                        radix          = 10;
                        if (word_start(c))
                        begin
                            kind_acc = nil_pkg::K_ID;
                            mode     = S_IDENT;
                        end
                        else if (dec_char(c))
                        begin
                            kind_acc = nil_pkg::K_INT;
                            mode     = (c == "0") ? S_ZERO : S_INT;
                        end
                        else
                        begin
                            made.push_back(make_token(nil_pkg::K_ILLEGAL, 1'b0, cur_line,
                                                      cur_col, nil_pkg::LEN_W'(1)));
                            tok_len = '0;
                        end
                    end
                end

                if (c == 8'h0A)
                begin
                    if (cur_line != '1)
                        cur_line++;
                    cur_col = nil_pkg::POS_W'(1);
                end
                else if (cur_col != '1)
                begin
                    cur_col++;
                end
            end

            foreach (made[i])
            begin
                made[i].last = (i == made.size() - 1);
                due_tokens.push_back(made[i]);
            end
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                fail_count++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_token(nil_pkg::token_t got);
            nil_pkg::token_t want;
            if (due_tokens.size() == 0)
            begin
                fail_count++;
                $error("token with no request behind it: kind %0d line %0d column %0d",
                       got.kind, got.line, got.column);
                return;
            end
            want = due_tokens.pop_front();
            check_field("token_kind", 32'(want.kind), 32'(got.kind));
            check_field("malformed", 32'(want.malformed), 32'(got.malformed));
            check_field("start_line", 32'(want.line), 32'(got.line));
            check_field("start_column", 32'(want.column), 32'(got.column));
            check_field("token_length", 32'(want.length), 32'(got.length));
            check_field("last_of_run", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [7:0]                 text_byte;
    logic                       end_of_text;
    logic                       out_valid;
    logic                       out_ready;
    logic [1:0]                 token_kind;
    logic                       malformed;
    logic [nil_pkg::POS_W-1:0]  start_line;
    logic [nil_pkg::POS_W-1:0]  start_column;
    logic [nil_pkg::LEN_W-1:0]  token_length;
    logic                       last_of_run;

    token_scoreboard    sb;
    int unsigned        cycle_count = 0;
    int                 byte_count  = 0;
    int                 stall_left  = 0;
    bit                 sender_calm = 1'b0;   // no gaps between requests
    bit                 drain_calm  = 1'b0;   // no output back-pressure

    number_and_identifier_lexer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .malformed    (malformed),
        .start_line   (start_line),
        .start_column (start_column),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

    always #5 clk = ~clk;

    // Hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // space, LF, CR, TAB, VT
    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0:       return 8'h20;
            1:       return 8'h0A;
            2:       return 8'h0D;
            3:       return 8'h09;
            default: return 8'h0B;
        endcase
    endfunction

    // Output back-pressure. Stalls are drawn here and held for their length;
    // drain_calm gives stretches where the sink always takes tokens.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!drain_calm && $urandom_range(0, 3) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= pick_gap();
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Token monitor. Inputs are driven by NBA at the edge, so the values seen
    // here are the ones the block sampled.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_token({token_kind, malformed, start_line, start_column,
                            token_length, last_of_run});
    end

    // One source request. Valid stays up into the next request when no gap
    // is drawn, so it is only lowered when idle cycles follow.
    task automatic send_item(input logic [7:0] b, input logic e);
        int gap;
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(b, e);
        if (!e)
            byte_count++;
        gap = sender_calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            // payload is garbage while idle; the block must ignore it
            in_valid    <= 1'b0;
            text_byte   <= 8'($urandom_range(0, 255));
            end_of_text <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        foreach (s[i])
            send_item(s[i], 1'b0);
    endtask

    // Stop sending until every token owed so far has come out
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // One random lexeme plus an optional separator. Mostly well-formed
    // literals with random content; some with missing digits, some illegal
    // bytes, raw noise and end-of-text flushes.
    task automatic send_lexeme();
        logic [8:0]  run[$];
        logic [7:0]  pfx;
        logic [7:0]  b;
        string       digs;
        int          r;
        int          n;

        r = $urandom_range(0, 99);
        if (r < 24)
        begin
            n = ($urandom_range(0, 199) == 0) ? $urandom_range(256, 280)
                                              : $urandom_range(1, 10);
            run.push_back({1'b0, pick(LETTERS)});
            repeat (n - 1) run.push_back({1'b0, pick(WORDCH)});
        end
        else if (r < 38)
        begin
            repeat ($urandom_range(1, 6)) run.push_back({1'b0, pick(DIGITS)});
        end
        else if (r < 54)
        begin
            pfx = pick("bBoOdDxX");
            case (pfx)
                "b", "B": digs = "01";
                "o", "O": digs = "01234567";
                "d", "D": digs = DIGITS;
                default:  digs = "0123456789abcdefABCDEF";
            endcase
            run.push_back({1'b0, 8'h30});
            run.push_back({1'b0, pfx});
            // prefix alone now and then: malformed
            n = ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(1, 6);
            repeat (n) run.push_back({1'b0, pick(digs)});
            if ($urandom_range(0, 9) == 0)
                run.push_back({1'b0, pick("0123456789abcdefxyzG")});
        end
        else if (r < 74)
        begin
            repeat ($urandom_range(1, 4)) run.push_back({1'b0, pick(DIGITS)});
            if ($urandom_range(0, 2) != 0)
            begin
                run.push_back({1'b0, 8'h2E});
                repeat ($urandom_range(0, 3)) run.push_back({1'b0, pick(DIGITS)});
            end
            if ($urandom_range(0, 1) != 0)
            begin
                run.push_back({1'b0, pick("eE")});
                if ($urandom_range(0, 1) != 0)
                    run.push_back({1'b0, pick("+-")});
                repeat ($urandom_range(0, 3)) run.push_back({1'b0, pick(DIGITS)});
            end
        end
        else if (r < 84)
        begin
            case ($urandom_range(0, 2))
                0: b = pick(PUNCT);
                1:
                begin
                    b = 8'($urandom_range(0, 31));
                    if (b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0D)
                        b = 8'h7F;
                end
                default: b = 8'($urandom_range(128, 255));
            endcase
            run.push_back({1'b0, b});
        end
        else if (r < 95)
        begin
            repeat ($urandom_range(1, 4)) run.push_back({1'b0, 8'($urandom_range(0, 255))});
        end
        else
        begin
            run.push_back({1'b1, 8'($urandom_range(0, 255))});
        end

        r = $urandom_range(0, 99);
        if (r < 60)
            run.push_back({1'b0, pick_blank()});
        else if (r < 75)
            repeat ($urandom_range(2, 5)) run.push_back({1'b0, pick_blank()});

        foreach (run[i])
            send_item(run[i][7:0], run[i][8]);
    endtask

    initial
    begin
        bit paused_once;

        paused_once = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        text_byte   = '0;
        end_of_text = 1'b0;
        sb          = new();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identifier, hex prefix, octal prefix cut short by an
        // out-of-base digit, dot and exponent both without digits, signed
        // exponent closed by a high byte (two tokens from one request),
        // NUL as illegal byte, vertical tab, flush, then a flush with
        // nothing open.
        send_text("_z9 0Xf 0o8 1.e 2E+5");
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h0B, 1'b0);
        send_item("7", 1'b0);
        send_item(8'hA5, 1'b1);
        send_item(8'h5A, 1'b1);

        // Random traffic with stretches of calm on either side
        while (byte_count < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 29) == 0)
                sender_calm = !sender_calm;
            if ($urandom_range(0, 29) == 0)
                drain_calm = !drain_calm;
            if (!paused_once && byte_count >= RANDOM_BYTES / 2)
            begin
                hold_until_drained();
                paused_once = 1'b1;
            end
            send_lexeme();
        end

        // Length ceiling: an identifier well past 255 bytes, then a few
        // closing tokens, a new line and a flush.
        hold_until_drained();
        sender_calm = 1'b1;
        send_item("k", 1'b0);
        repeat (299) send_item(pick(WORDCH), 1'b0);
        send_text(" ab 12.5e3 0x ");
        send_text("x9#7 ");
        send_item(8'h0A, 1'b0);
        send_text("q");
        send_item(8'h00, 1'b1);
        sender_calm = 1'b0;

        // Drain what is still owed, then give the block time to show any
        // stray token
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (sb.fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* number_and_identifier_lexer.f */
design/nil_pkg.sv
design/nil_scan.sv
design/nil_outq.sv
design/number_and_identifier_lexer.sv
design/nil_checker.sv
bench/tb_number_and_identifier_lexer.sv
